/* src/smtc_pkg.sv */
// ----------------------------------------------------------------------------
// smtc_pkg
// Shared types and constants for the segment median track classifier.
// ----------------------------------------------------------------------------
package smtc_pkg;

  localparam int GROUPS_DEF      = 5;
  localparam int COLUMN_BITS_DEF = 7;

  localparam int MED_N      = 5;
  localparam int CNT_W      = 3;
  localparam int SEG_W      = 3;
  localparam int DEV_OUT_W  = 8;
  localparam int CENTER_W   = 7;
  localparam int BAND_W     = 8;
  localparam int SUM_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COLUMN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_BAND = 2'd1;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 7'd40;
  localparam logic [BAND_W-1:0]   BAND_RESET   = 8'd25;

  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_LEFT     = 2'd1,
    DIR_RIGHT    = 2'd2
  } dir_t;

endpackage

/* src/smtc_median5.sv */
// ----------------------------------------------------------------------------
// smtc_median5
// Median of five columns by parallel rank counting, ties broken by position.
// ----------------------------------------------------------------------------
module smtc_median5 #(
  parameter int COLUMN_BITS = smtc_pkg::COLUMN_BITS_DEF
) (
  input  logic [smtc_pkg::MED_N-1:0][COLUMN_BITS-1:0] samples,
  output logic [COLUMN_BITS-1:0]                      median
);
  import smtc_pkg::*;

  logic [CNT_W-1:0] rank [MED_N];

  always_comb begin
    for (int i = 0; i < MED_N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MED_N; j++) begin
        if (j != i) begin
          if ((samples[j] < samples[i]) || ((samples[j] == samples[i]) && (j < i))) begin
            rank[i] = rank[i] + CNT_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < MED_N; i++) begin
      if (rank[i] == CNT_W'(MED_N / 2)) begin
        median = median | samples[i];
      end
    end
  end

endmodule

/* src/segment_median_track_classifier.sv */
// ----------------------------------------------------------------------------
// segment_median_track_classifier
// Median-of-five segment deviation and straight/left/right track class.
// ----------------------------------------------------------------------------
// One row column is taken per cycle while input ready is high. A transfer lands
// in an input register; from there the median network, deviation subtract and
// class compare run in one pass into the result register once that register is
// free, so a group's result follows its fifth row through the input and result
// registers. Input ready drops only while a result waits in the result register
// and the held row would make another one.
module segment_median_track_classifier #(
  parameter int GROUPS      = smtc_pkg::GROUPS_DEF,
  parameter int COLUMN_BITS = smtc_pkg::COLUMN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COLUMN_BITS-1:0]           in_center_x,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [smtc_pkg::SEG_W-1:0]       out_segment_index,
  output logic [smtc_pkg::DEV_OUT_W-1:0]   out_deviation,
  output logic [1:0]                       out_direction,
  output logic                             out_frame_done
);
  import smtc_pkg::*;

  localparam int HELD  = MED_N - 1;
  localparam int DEV_W = ((COLUMN_BITS > CENTER_W) ? COLUMN_BITS : CENTER_W) + 2;
  localparam logic signed [DEV_W-1:0] DEV_MAX = DEV_W'(127);
  localparam logic signed [DEV_W-1:0] DEV_MIN = -DEV_W'(127);
  localparam logic [CNT_W-1:0] LAST_GROUP = CNT_W'(GROUPS - 1);

  logic [CENTER_W-1:0]    center_column_r;
  logic [BAND_W-1:0]      straight_band_r;

  logic                   s1_valid_r;
  logic [COLUMN_BITS-1:0] s1_col_r;
  logic                   s1_fs_r;

  logic [COLUMN_BITS-1:0] group_samples_r [HELD];
  logic [CNT_W-1:0]       sample_count_r, sample_count_nxt;
  logic [CNT_W-1:0]       group_count_r, group_count_nxt;
  logic [DEV_OUT_W-1:0]   prev_dev_r;

  logic                   out_valid_r;
  logic [SEG_W-1:0]       seg_r;
  logic [DEV_OUT_W-1:0]   dev_r;
  dir_t                   dir_r, dir_nxt;
  logic                   done_r;

  logic [CNT_W-1:0]       sc_eff, gc_eff;
  logic                   s1_has_out, out_free, s1_fire, last_group;
  logic [MED_N-1:0][COLUMN_BITS-1:0] med_in;
  logic [COLUMN_BITS-1:0] median;
  logic signed [DEV_W-1:0] dev_full;
  logic [DEV_OUT_W-1:0]   dev_sat;
  logic signed [SUM_W-1:0] sum, band_s;

  assign cfg_ready = 1'b1;

  assign sc_eff     = s1_fs_r ? '0 : sample_count_r;
  assign gc_eff     = s1_fs_r ? '0 : group_count_r;
  assign s1_has_out = (sc_eff == CNT_W'(HELD));
  assign out_free   = !out_valid_r || out_ready;
  assign s1_fire    = s1_valid_r && (!s1_has_out || out_free);
  assign in_ready   = !s1_valid_r || s1_fire;
  assign last_group = (gc_eff >= LAST_GROUP);

  always_comb begin
    for (int i = 0; i < HELD; i++) begin
      med_in[i] = group_samples_r[i];
    end
    med_in[HELD] = s1_col_r;
  end

  smtc_median5 #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_median (
    .samples(med_in),
    .median (median)
  );

  assign dev_full = $signed(DEV_W'(median)) - $signed(DEV_W'(center_column_r));

  always_comb begin
    if (dev_full > DEV_MAX) begin
      dev_sat = DEV_MAX[DEV_OUT_W-1:0];
    end else if (dev_full < DEV_MIN) begin
      dev_sat = DEV_MIN[DEV_OUT_W-1:0];
    end else begin
      dev_sat = dev_full[DEV_OUT_W-1:0];
    end
  end

  assign sum    = $signed({{(SUM_W-DEV_OUT_W){prev_dev_r[DEV_OUT_W-1]}}, prev_dev_r})
                + $signed({{(SUM_W-DEV_OUT_W){dev_sat[DEV_OUT_W-1]}}, dev_sat});
  assign band_s = $signed({{(SUM_W-BAND_W){1'b0}}, straight_band_r});

  always_comb begin
    if (!last_group) begin
      dir_nxt = DIR_STRAIGHT;
    end else if (sum > band_s) begin
      dir_nxt = DIR_LEFT;
    end else if (sum < -band_s) begin
      dir_nxt = DIR_RIGHT;
    end else begin
      dir_nxt = DIR_STRAIGHT;
    end
  end

  always_comb begin
    sample_count_nxt = sample_count_r;
    group_count_nxt  = group_count_r;
    if (s1_fire) begin
      if (!s1_has_out) begin
        sample_count_nxt = sc_eff + CNT_W'(1);
        group_count_nxt  = gc_eff;
      end else begin
        sample_count_nxt = '0;
        group_count_nxt  = last_group ? '0 : gc_eff + CNT_W'(1);
      end
    end
  end

  // Configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_column_r <= CENTER_RESET;
      straight_band_r <= BAND_RESET;
      s1_valid_r      <= 1'b0;
      sample_count_r  <= '0;
      group_count_r   <= '0;
      prev_dev_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CENTER_COLUMN: center_column_r <= cfg_data[CENTER_W-1:0];
          CFG_STRAIGHT_BAND: straight_band_r <= cfg_data[BAND_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      sample_count_r <= sample_count_nxt;
      group_count_r  <= group_count_nxt;
      if (s1_fire && s1_has_out) begin
        prev_dev_r  <= dev_sat;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_col_r <= in_center_x;
      s1_fs_r  <= in_frame_start;
    end
    if (s1_fire && !s1_has_out) begin
      group_samples_r[sc_eff[1:0]] <= s1_col_r;
    end
    if (s1_fire && s1_has_out) begin
      seg_r  <= gc_eff;
      dev_r  <= dev_sat;
      dir_r  <= dir_nxt;
      done_r <= last_group;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_index = seg_r;
  assign out_deviation     = dev_r;
  assign out_direction     = dir_r;
  assign out_frame_done    = done_r;

  a_sample_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r <= CNT_W'(HELD))
    else $error("sample count beyond group size");

  a_group_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    group_count_r <= LAST_GROUP)
    else $error("group count beyond last group");

  a_dir_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !done_r) |-> (dir_r == DIR_STRAIGHT))
    else $error("direction set outside last group");

  a_done_on_last_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (done_r == (seg_r == LAST_GROUP)))
    else $error("frame done does not match last segment");

endmodule
